### sv/dhip_pkg.sv
// ----------------------------------------------------------------------------
// dhip_pkg
// Shared types and constants for the decimal/hex integer parser.
// ----------------------------------------------------------------------------
package dhip_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int COUNT_BITS  = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(255);

  // character codes
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] HEX_ALPHA_BIAS = 8'd10;

  typedef enum logic [2:0] {
    CL_WS,
    CL_MINUS,
    CL_ZERO,
    CL_DEC,
    CL_X,
    CL_HEX_ALPHA,
    CL_OTHER
  } char_class_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_ZERO,
    PH_DEC,
    PH_HEX,
    PH_TRAIL,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic        term;
    char_class_t cls;
    logic [3:0]  digit;
  } token_t;

endpackage

### sv/dhip_in_if.sv
// ----------------------------------------------------------------------------
// dhip_in_if
// Character channel: one string byte or a terminator per transaction.
// ----------------------------------------------------------------------------
interface dhip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_terminator;

  modport source (output valid, output char_code, output is_terminator, input ready);
  modport sink   (input valid, input char_code, input is_terminator, output ready);
endinterface

### sv/dhip_out_if.sv
// ----------------------------------------------------------------------------
// dhip_out_if
// Result channel: parsed value, consumed count and stop reason.
// ----------------------------------------------------------------------------
interface dhip_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] parsed_value;
  logic [7:0]         chars_consumed;
  logic               stopped_at_end;

  modport source (output valid, output parsed_value, output chars_consumed,
                  output stopped_at_end, input ready);
  modport sink   (input valid, input parsed_value, input chars_consumed,
                  input stopped_at_end, output ready);
endinterface

### sv/dhip_front.sv
// ----------------------------------------------------------------------------
// dhip_front
// Accepts characters and classifies each into a token for the back end.
// ----------------------------------------------------------------------------
module dhip_front (
  dhip_in_if.sink          chars,
  input  logic             q_full,
  output logic             push,
  output dhip_pkg::token_t push_token
);
  import dhip_pkg::*;

  logic [7:0] c;
  logic [7:0] alpha_off;

  assign c           = chars.char_code;
  assign chars.ready = !q_full;
  assign push        = chars.valid && !q_full;

  always_comb begin
    alpha_off = 8'd0;
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      alpha_off = c - CH_LOWER_A + HEX_ALPHA_BIAS;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      alpha_off = c - CH_UPPER_A + HEX_ALPHA_BIAS;
    end
  end

  always_comb begin
    push_token.term  = chars.is_terminator;
    push_token.digit = 4'd0;
    if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
      push_token.cls = CL_WS;
    end else if (c == CH_MINUS) begin
      push_token.cls = CL_MINUS;
    end else if (c == CH_ZERO) begin
      push_token.cls = CL_ZERO;
    end else if (c > CH_ZERO && c <= CH_NINE) begin
      push_token.cls   = CL_DEC;
      push_token.digit = 4'(c - CH_ZERO);
    end else if (c == CH_LOWER_X || c == CH_UPPER_X) begin
      push_token.cls = CL_X;
    end else if ((c >= CH_LOWER_A && c <= CH_LOWER_F) ||
                 (c >= CH_UPPER_A && c <= CH_UPPER_F)) begin
      push_token.cls   = CL_HEX_ALPHA;
      push_token.digit = alpha_off[3:0];
    end else begin
      push_token.cls = CL_OTHER;
    end
  end

endmodule

### sv/dhip_queue.sv
// ----------------------------------------------------------------------------
// dhip_queue
// Short token FIFO between the classifier and the parse engine.
// ----------------------------------------------------------------------------
module dhip_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dhip_pkg::token_t push_token,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output dhip_pkg::token_t head
);
  import dhip_pkg::*;

  token_t               slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   fill;

  assign full      = (fill == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### sv/dhip_back.sv
// ----------------------------------------------------------------------------
// dhip_back
// Parse engine: phase machine, accumulator, count and result register.
// ----------------------------------------------------------------------------
module dhip_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  dhip_pkg::token_t head,
  output logic             pop,
  dhip_out_if.source       results
);
  import dhip_pkg::*;

  phase_t                phase, phase_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic                  neg, neg_next;
  logic [COUNT_BITS-1:0] count, count_next;

  logic                  accept;
  logic                  emit;
  logic                  clear;
  logic                  add_dec;
  logic                  add_hex;
  logic [VALUE_BITS-1:0] value_out;

  // advance only when the result register is free or being drained
  assign pop = q_valid && (!results.valid || results.ready);

  // next phase
  always_comb begin
    phase_next = phase;
    if (head.term) begin
      phase_next = PH_LEAD;
    end else begin
      case (phase)
        PH_LEAD, PH_SIGN: begin
          if (phase == PH_LEAD && head.cls == CL_WS)         phase_next = PH_LEAD;
          else if (phase == PH_LEAD && head.cls == CL_MINUS) phase_next = PH_SIGN;
          else if (head.cls == CL_ZERO)                      phase_next = PH_ZERO;
          else if (head.cls == CL_DEC)                       phase_next = PH_DEC;
          else if (head.cls == CL_WS)                        phase_next = PH_TRAIL;
          else                                               phase_next = PH_DONE;
        end
        PH_ZERO: begin
          if (head.cls == CL_X)                                  phase_next = PH_HEX;
          else if (head.cls == CL_ZERO || head.cls == CL_DEC)    phase_next = PH_DEC;
          else if (head.cls == CL_WS)                            phase_next = PH_TRAIL;
          else                                                   phase_next = PH_DONE;
        end
        PH_DEC: begin
          if (head.cls == CL_ZERO || head.cls == CL_DEC) phase_next = PH_DEC;
          else if (head.cls == CL_WS)                    phase_next = PH_TRAIL;
          else                                           phase_next = PH_DONE;
        end
        PH_HEX: begin
          if (head.cls == CL_ZERO || head.cls == CL_DEC || head.cls == CL_HEX_ALPHA)
            phase_next = PH_HEX;
          else if (head.cls == CL_WS) phase_next = PH_TRAIL;
          else                        phase_next = PH_DONE;
        end
        PH_TRAIL: begin
          if (head.cls == CL_WS) phase_next = PH_TRAIL;
          else                   phase_next = PH_DONE;
        end
        PH_DONE:  phase_next = PH_DONE;
        default:  phase_next = PH_DONE;
      endcase
    end
  end

  // per-token actions
  always_comb begin
    accept  = 1'b0;
    emit    = 1'b0;
    clear   = 1'b0;
    add_dec = 1'b0;
    add_hex = 1'b0;
    if (head.term) begin
      clear = 1'b1;
      emit  = (phase != PH_DONE);
    end else begin
      case (phase)
        PH_LEAD, PH_SIGN: begin
          accept  = (phase_next != PH_DONE);
          add_dec = (head.cls == CL_DEC);
        end
        PH_ZERO, PH_DEC: begin
          accept  = (phase_next != PH_DONE);
          add_dec = (head.cls == CL_ZERO || head.cls == CL_DEC);
        end
        PH_HEX: begin
          accept  = (phase_next != PH_DONE);
          add_hex = (head.cls == CL_ZERO || head.cls == CL_DEC ||
                     head.cls == CL_HEX_ALPHA);
        end
        PH_TRAIL: accept = (head.cls == CL_WS);
        PH_DONE:  accept = 1'b0;
        default:  accept = 1'b0;
      endcase
      emit = !accept && (phase != PH_DONE);
    end
  end

  // datapath next values
  always_comb begin
    acc_next   = acc;
    neg_next   = neg;
    count_next = count;
    if (clear) begin
      acc_next   = '0;
      neg_next   = 1'b0;
      count_next = '0;
    end else begin
      if (add_dec) begin
        acc_next = (acc << 3) + (acc << 1) + VALUE_BITS'(head.digit);
      end else if (add_hex) begin
        acc_next = (acc << 4) + VALUE_BITS'(head.digit);
      end
      if (phase == PH_LEAD && head.cls == CL_MINUS) begin
        neg_next = 1'b1;
      end
      if (accept && count != COUNT_MAX) begin
        count_next = count + 1'b1;
      end
    end
  end

  assign value_out = neg ? (VALUE_BITS'(0) - acc) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEAD;
      acc   <= '0;
      neg   <= 1'b0;
      count <= '0;
    end else if (pop) begin
      phase <= phase_next;
      acc   <= acc_next;
      neg   <= neg_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (pop && emit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      results.parsed_value   <= value_out[31:0];
      results.chars_consumed <= count;
      results.stopped_at_end <= head.term;
    end
  end

endmodule

### sv/dec_hex_integer_parser.sv
// ----------------------------------------------------------------------------
// dec_hex_integer_parser
// Streaming signed decimal / hex string-to-integer parser.
// ----------------------------------------------------------------------------
// One character enters per transaction on chars; a transaction with
// is_terminator set closes the string. Leading whitespace is skipped, an
// optional '-' is taken, "0x"/"0X" selects hex, else digits are decimal; the
// 32-bit value wraps and is negated for '-'. Trailing whitespace is skipped.
// At the first rejected character, or at the terminator, one result leaves on
// results: value, characters consumed (saturating at 255) and whether the
// terminator ended the parse. After a rejection the rest of the string is
// dropped and its terminator only rearms the parser. The block takes one
// character per clock while its queue has room: the classifier feeds a
// four-entry token queue, and the parse engine retires one token per cycle
// while no result waits, through its phase machine and a shift-and-add
// accumulator. A result passes the token queue and then the result register.
// The result register stalls the engine only while a result waits to be
// taken; the queue keeps accepting characters meanwhile, up to four, and
// only then drops ready on chars.
// ----------------------------------------------------------------------------
module dec_hex_integer_parser (
  input  logic       clk,
  input  logic       rst,
  dhip_in_if.sink    chars,
  dhip_out_if.source results
);
  import dhip_pkg::*;

  logic   q_full;
  logic   q_not_empty;
  logic   push;
  logic   pop;
  token_t push_token;
  token_t head;

  // classify incoming characters
  dhip_front u_front (
    .chars      (chars),
    .q_full     (q_full),
    .push       (push),
    .push_token (push_token)
  );

  // decouple classifier from parse engine
  dhip_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  // run the phase machine and hold results
  dhip_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_not_empty),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

### bench/dhip_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dhip_result_checker
// Watches both channels of the parser, predicts each result, and compares.
// ----------------------------------------------------------------------------
module dhip_result_checker (
  input  logic clk,
  input  logic rst,
  dhip_in_if   chars,
  dhip_out_if  results,
  output int   fail_count,
  output int   results_pending,
  output int   results_checked,
  output int   rejects_checked
);
  import dhip_pkg::*;

  localparam logic [31:0] RADIX_DEC   = 32'd10;
  localparam logic [31:0] RADIX_HEX   = 32'd16;
  localparam int          MAX_REPORTS = 40;

  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]         count;
    logic               at_end;
  } parse_result_t;

  parse_result_t pending_results[$];

  // predicted parser state
  phase_t      parse_ph;
  logic [31:0] parse_acc;
  logic        parse_neg;
  logic [7:0]  parse_cnt;

  function automatic bit is_space(logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
  endfunction

  function automatic bit is_decimal(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // digit value for hex, or -1 when c is no hex digit
  function automatic int hex_digit(logic [7:0] c);
    if (is_decimal(c)) return int'(c) - int'(CH_ZERO);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F)
      return int'(c) - int'(CH_LOWER_A) + int'(HEX_ALPHA_BIAS);
    if (c >= CH_UPPER_A && c <= CH_UPPER_F)
      return int'(c) - int'(CH_UPPER_A) + int'(HEX_ALPHA_BIAS);
    return -1;
  endfunction

  task automatic restart_parse();
    parse_ph  = PH_LEAD;
    parse_acc = '0;
    parse_neg = 1'b0;
    parse_cnt = '0;
  endtask

  task automatic push_result(input logic at_end);
    parse_result_t r;
    r.value  = parse_neg ? -parse_acc : parse_acc;
    r.count  = parse_cnt;
    r.at_end = at_end;
    pending_results.push_back(r);
  endtask

  // Advance the predicted parser by one character transaction.
  task automatic advance_parse(input logic [7:0] c, input logic term);
    logic taken;
    int   dv;
    taken = 1'b0;
    dv    = hex_digit(c);
    if (term) begin
      // a terminator after a rejection only rearms
      if (parse_ph != PH_DONE) push_result(1'b1);
      restart_parse();
      return;
    end
    case (parse_ph)
      PH_LEAD, PH_SIGN: begin
        if (parse_ph == PH_LEAD && is_space(c)) begin
          taken = 1'b1;
        end else if (parse_ph == PH_LEAD && c == CH_MINUS) begin
          parse_neg = 1'b1;
          parse_ph  = PH_SIGN;
          taken     = 1'b1;
        end else if (c == CH_ZERO) begin
          parse_ph = PH_ZERO;
          taken    = 1'b1;
        end else if (is_decimal(c)) begin
          parse_acc = parse_acc * RADIX_DEC + 32'(dv);
          parse_ph  = PH_DEC;
          taken     = 1'b1;
        end else if (is_space(c)) begin
          parse_ph = PH_TRAIL;
          taken    = 1'b1;
        end
      end
      PH_ZERO: begin
        if (c == CH_LOWER_X || c == CH_UPPER_X) begin
          parse_ph = PH_HEX;
          taken    = 1'b1;
        end else if (is_decimal(c)) begin
          parse_acc = parse_acc * RADIX_DEC + 32'(dv);
          parse_ph  = PH_DEC;
          taken     = 1'b1;
        end else if (is_space(c)) begin
          parse_ph = PH_TRAIL;
          taken    = 1'b1;
        end
      end
      PH_DEC: begin
        if (is_decimal(c)) begin
          parse_acc = parse_acc * RADIX_DEC + 32'(dv);
          taken     = 1'b1;
        end else if (is_space(c)) begin
          parse_ph = PH_TRAIL;
          taken    = 1'b1;
        end
      end
      PH_HEX: begin
        if (dv >= 0) begin
          parse_acc = parse_acc * RADIX_HEX + 32'(dv);
          taken     = 1'b1;
        end else if (is_space(c)) begin
          parse_ph = PH_TRAIL;
          taken    = 1'b1;
        end
      end
      PH_TRAIL: taken = is_space(c);
      default: return;
    endcase
    if (taken) begin
      if (parse_cnt != COUNT_MAX) parse_cnt = parse_cnt + 8'd1;
    end else begin
      push_result(1'b0);
      parse_ph = PH_DONE;
    end
  endtask

  task automatic report(input string msg);
    if (fail_count < MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_result();
    parse_result_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("result %0d/%0d/%0d with nothing pending", results.parsed_value,
                       results.chars_consumed, results.stopped_at_end));
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (!want.at_end) rejects_checked++;
    if (results.parsed_value !== want.value)
      report($sformatf("parsed_value %0d, want %0d", results.parsed_value, want.value));
    if (results.chars_consumed !== want.count)
      report($sformatf("chars_consumed %0d, want %0d", results.chars_consumed, want.count));
    if (results.stopped_at_end !== want.at_end)
      report($sformatf("stopped_at_end %0b, want %0b", results.stopped_at_end, want.at_end));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_parse();
      pending_results.delete();
      fail_count      = 0;
      results_checked = 0;
      rejects_checked = 0;
    end else begin
      if (chars.valid && chars.ready) advance_parse(chars.char_code, chars.is_terminator);
      if (results.valid && results.ready) check_result();
    end
    results_pending <= pending_results.size();
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the streaming decimal/hex integer parser.
// ----------------------------------------------------------------------------
// Strings go in one character per transaction, each closed by a terminator
// transaction. A short directed part walks the prefix, sign, zero and
// rejection corners; then random strings follow, mostly well formed numbers
// with random content, the rest noise and broken prefixes, plus a long
// string for value wrap and a very long one for count saturation. The run
// steps through four handshake phases (no idling, sender idle, receiver
// stalling, both), holds the receiver off for a long stretch once and lets
// the sender pause until all results are back once. dhip_result_checker
// predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import dhip_pkg::*;

  localparam int WATCHDOG_NS     = 2_000_000;
  localparam int PHASE_CHARS     = 110;
  localparam int LONG_HOLD       = 80;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 8;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_UPPER_G = 8'h47;

  logic clk;
  logic rst;

  dhip_in_if  char_bus ();
  dhip_out_if result_bus ();

  int fail_count;
  int results_pending;
  int results_checked;
  int rejects_checked;

  // knobs handed from the stimulus to the receiver process
  int   stall_pct;
  logic hold_req;

  int         idle_pct;
  int         chars_sent;
  int         strings_sent;
  logic [7:0] text_buf[$];

  dec_hex_integer_parser i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (char_bus),
    .results (result_bus)
  );

  dhip_result_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .chars           (char_bus),
    .results         (result_bus),
    .fail_count      (fail_count),
    .results_pending (results_pending),
    .results_checked (results_checked),
    .rejects_checked (rejects_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop for a hung run.
  initial begin
    #(WATCHDOG_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: stall at random, and on a toggle of hold_req hold ready low until
  // a countdown from LONG_HOLD ends, so the parser backs up into its input.
  initial begin
    int   hold_left;
    logic hold_ack;
    hold_left = 0;
    hold_ack  = 1'b0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_bus.ready <= 1'b0;
        hold_ack = hold_req;
      end else if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD;
        result_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one character transaction, with random idle cycles ahead of it,
  // and hold it until the parser takes it.
  task automatic send_item(input logic [7:0] c, input logic term);
    while ($urandom_range(99) < idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk);
    end
    char_bus.valid         <= 1'b1;
    char_bus.char_code     <= c;
    char_bus.is_terminator <= term;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    chars_sent++;
  endtask

  // Send text_buf, then a terminator carrying a random (ignored) byte.
  task automatic send_text();
    foreach (text_buf[i]) send_item(text_buf[i], 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
    strings_sent++;
    text_buf.delete();
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // one of the whitespace codes: tab through carriage return, or space
  function automatic logic [7:0] rand_space();
    int v;
    v = $urandom_range(5);
    return (v == 5) ? CH_SPACE : CH_TAB + 8'(v);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int d;
    d = $urandom_range(15);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + 8'(d - 10);
  endfunction

  // Build one random string: mostly well formed numbers, some noise, some
  // broken prefixes made of the characters the parser cares about.
  task automatic build_random_text();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 70) begin
      n = $urandom_range(3);
      repeat (n) text_buf.push_back(rand_space());
      if ($urandom_range(99) < 40) text_buf.push_back(CH_MINUS);
      if ($urandom_range(99) < 30) begin
        text_buf.push_back(CH_ZERO);
        text_buf.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
        n = $urandom_range(10);
        repeat (n) text_buf.push_back(rand_hex_char());
      end else begin
        n = $urandom_range(1, 12);
        repeat (n) text_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
      end
      n = $urandom_range(2);
      repeat (n) text_buf.push_back(rand_space());
      // trailing junk: a rejection followed by dropped characters
      if ($urandom_range(99) < 25) begin
        n = $urandom_range(1, 3);
        repeat (n) text_buf.push_back(8'($urandom_range(255)));
      end
    end else if (kind < 88) begin
      n = $urandom_range(6);
      repeat (n) text_buf.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        case ($urandom_range(8))
          0: text_buf.push_back(rand_space());
          1: text_buf.push_back(CH_MINUS);
          2: text_buf.push_back(CH_ZERO);
          3: text_buf.push_back(CH_LOWER_X);
          4: text_buf.push_back(CH_UPPER_X);
          5: text_buf.push_back(CH_PLUS);
          6: text_buf.push_back(CH_LOWER_A);
          7: text_buf.push_back(CH_UPPER_G);
          default: text_buf.push_back(CH_NINE);
        endcase
      end
    end
  endtask

  // Drop valid and wait until every expected result is back.
  task automatic pause_until_drained();
    char_bus.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  initial begin
    int wait_cycles;
    rst                    <= 1'b1;
    char_bus.valid         <= 1'b0;
    char_bus.char_code     <= '0;
    char_bus.is_terminator <= 1'b0;
    stall_pct              <= 0;
    hold_req               <= 1'b0;
    idle_pct     = 0;
    chars_sent   = 0;
    strings_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed corners.
    load_text("0x");           // prefix without hex digits
    send_text();
    load_text("07");           // lone zero is a decimal digit
    send_text();
    load_text("- 5");          // whitespace after a sign, then a rejection
    send_text();               // and a terminator while waiting
    load_text("-0XfF");        // negative hex, both letter cases
    send_text();
    load_text("+");            // plus is never taken
    send_text();
    text_buf.push_back(8'hFF); // top byte value
    send_text();
    text_buf.push_back(8'h00); // NUL as a plain character
    send_text();
    text_buf.push_back(CH_TAB);
    load_text("99");
    text_buf.push_back(CH_CR);
    send_text();

    // Random strings over four handshake phases.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 51; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 51; end
        default: begin idle_pct = 29; stall_pct <= 29; end
      endcase
      // hold the receiver off while the sender keeps offering
      if (ph == 2) hold_req <= ~hold_req;
      // let the sender sit until the pipe is empty
      if (ph == 3) pause_until_drained();
      wait_cycles = chars_sent + PHASE_CHARS;
      while (chars_sent < wait_cycles) begin
        build_random_text();
        send_text();
      end
      // long strings: value wrap, then count saturation
      if (ph == 1) begin
        repeat (20) text_buf.push_back(rand_space());
        text_buf.push_back(CH_MINUS);
        repeat (60) text_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
        send_text();
      end
      if (ph == 3) begin
        text_buf.push_back(CH_ZERO);
        text_buf.push_back(CH_LOWER_X);
        repeat (270) text_buf.push_back(rand_hex_char());
        send_text();
      end
    end

    // Drain and settle.
    char_bus.valid <= 1'b0;
    stall_pct      <= 0;
    @(posedge clk);
    wait_cycles = 0;
    while (results_pending != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (results_pending != 0) $display("%0d expected results never arrived", results_pending);
    $display("Covered %0d characters in %0d strings across four handshake phases,",
             chars_sent, strings_sent);
    $display("a long receiver hold-off and a drain pause; %0d results, %0d on rejection",
             results_checked, rejects_checked);
    if (fail_count == 0 && results_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
